// ----- design/hcpg_pkg.sv -----
// shared constants, cell payload types and the base point table of the hilbert point generator
package hcpg_pkg;

	localparam int ORDER_MAX = 8;
	localparam int CFG_W     = 4;
	localparam int IDX_W     = 2 * ORDER_MAX;
	localparam int POS_W     = 2 * ORDER_MAX + 1;
	localparam int COORD_W   = ORDER_MAX + 1;
	localparam int CELLS     = ORDER_MAX - 1;
	localparam int QD_W      = 2 * CELLS;
	localparam int LVL_W     = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
	localparam int SH_W      = $clog2(IDX_W + 1);
	localparam int IN_W      = 8;
	localparam int OUT_W     = ((2 * COORD_W + 7) / 8) * 8;
	localparam int PAD_W     = OUT_W - 2 * COORD_W;

	// quadrant codes
	localparam logic [1:0] QUAD_REV = 2'd0;
	localparam logic [1:0] QUAD_LL  = 2'd1;
	localparam logic [1:0] QUAD_UL  = 2'd2;
	localparam logic [1:0] QUAD_UR  = 2'd3;

	// payload of a descending cell: index peeled from the top, quadrants collected
	typedef struct packed {
		logic               ok;
		logic               last;
		logic [LVL_W-1:0]   depth;
		logic [LVL_W-1:0]   cnt;
		logic [IDX_W-1:0]   idx;
		logic [QD_W-1:0]    quads;
	} desc_t;

	// payload of an ascending cell: point grown level by level
	typedef struct packed {
		logic               ok;
		logic               last;
		logic [LVL_W-1:0]   cnt;
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] n;
		logic [QD_W-1:0]    quads;
	} asc_t;

	// order-1 curve: (2,1) (1,1) (1,2) (2,2)
	function automatic logic [COORD_W-1:0] base_x(input logic [1:0] sel);
		logic [COORD_W-1:0] r;
		unique case (sel)
			2'd0:    r = COORD_W'(2);
			2'd1:    r = COORD_W'(1);
			2'd2:    r = COORD_W'(1);
			default: r = COORD_W'(2);
		endcase
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] base_y(input logic [1:0] sel);
		logic [COORD_W-1:0] r;
		unique case (sel)
			2'd0:    r = COORD_W'(1);
			2'd1:    r = COORD_W'(1);
			2'd2:    r = COORD_W'(2);
			default: r = COORD_W'(2);
		endcase
		return r;
	endfunction

endpackage

// ----- design/hcpg_desc_cell.sv -----
// descending cell: takes one quadrant off the top of the index per active level
module hcpg_desc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hcpg_pkg::desc_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output hcpg_pkg::desc_t out_data
);

	logic            v_q;
	hcpg_pkg::desc_t d_q;
	hcpg_pkg::desc_t nxt;

	always_comb begin
		logic [1:0]                 q;
		logic [hcpg_pkg::IDX_W-1:0] rest;
		q    = in_data.idx[hcpg_pkg::IDX_W-1 -: 2];
		rest = in_data.idx << 2;
		nxt  = in_data;
		if (in_data.cnt != '0) begin
			// reversed quadrant walks its sub-curve backwards
			if (q == hcpg_pkg::QUAD_REV) begin
				rest = ~rest;
			end
			nxt.idx   = rest;
			nxt.quads = {in_data.quads[hcpg_pkg::QD_W-3:0], q};
			nxt.cnt   = in_data.cnt - 1'b1;
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

endmodule

// ----- design/hcpg_asc_cell.sv -----
// ascending cell: maps the sub-point into its quadrant, one level per active cell
module hcpg_asc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hcpg_pkg::asc_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hcpg_pkg::asc_t out_data
);

	logic           v_q;
	hcpg_pkg::asc_t d_q;
	hcpg_pkg::asc_t nxt;

	always_comb begin
		logic [1:0] q;
		q   = in_data.quads[1:0];
		nxt = in_data;
		if (in_data.cnt != '0) begin
			unique case (q)
				hcpg_pkg::QUAD_REV: begin
					nxt.a = in_data.b + in_data.n;
					nxt.b = in_data.n - in_data.a + 1'b1;
				end
				hcpg_pkg::QUAD_LL: begin
					nxt.a = in_data.a;
					nxt.b = in_data.b;
				end
				hcpg_pkg::QUAD_UL: begin
					nxt.a = in_data.a;
					nxt.b = in_data.b + in_data.n;
				end
				default: begin
					nxt.a = in_data.b + in_data.n;
					nxt.b = in_data.a + in_data.n;
				end
			endcase
			nxt.quads = in_data.quads >> 2;
			nxt.n     = in_data.n << 1;
			nxt.cnt   = in_data.cnt - 1'b1;
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

endmodule

// ----- design/hilbert_curve_point_generator_unit.sv -----
// top level of the hilbert curve point generator: position counter and cell chains
//
// each transfer on the s_ channel requests the next point of a hilbert curve whose
// order is set through cfg_we/cfg_wdata (0 acts as 1, above 8 acts as 8). the point
// comes out on the m_ channel as 1-based (x, y) on a grid of side 2^order, with
// m_tlast on the final point. once the curve is used up every request gives a
// result with x = y = 0, m_tuser low and m_tlast low; the counter stays put.
// restart in s_tdata zeroes the position before that request is served.
// the request enters a front stage that owns the position counter, then a chain of
// 7 descending cells that strip quadrants off the index, then 7 ascending cells
// that build the point back up; cells above the configured order pass data through.
// the s_ transfer passes through all 2 * 8 - 1 = 15 registered stages to m_tvalid.
// throughput is one point per cycle unless m_tready stalls; each stage registers.
// a stalled receiver (m_tready low) holds the last cell; stages behind it keep
// filling their empty slots, so s_tready only drops once all 15 stages hold items.
// reset (arst_n low) empties all stages, clears the position and sets order to 1.
// order must be written only while the block is idle; it does not enforce this.
module hilbert_curve_point_generator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hcpg_pkg::CFG_W-1:0]   cfg_wdata,    // order
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hcpg_pkg::IN_W-1:0]    s_tdata,      // [0] restart, rest zero
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hcpg_pkg::OUT_W-1:0]   m_tdata,      // x, y, zero fill
	output logic                         m_tuser,      // valid_res
	output logic                         m_tlast       // last
);

	localparam int CELLS = hcpg_pkg::CELLS;

	logic [hcpg_pkg::CFG_W-1:0] order_q;
	logic [hcpg_pkg::CFG_W-1:0] k_eff;
	logic [hcpg_pkg::POS_W-1:0] position_q;
	logic [hcpg_pkg::POS_W-1:0] pos_eff;
	logic [hcpg_pkg::POS_W-1:0] total;
	logic [hcpg_pkg::SH_W-1:0]  align_sh;
	logic                       exhausted;
	logic                       s_xfer;
	hcpg_pkg::desc_t            front_nxt;
	logic                       front_valid_s1;
	hcpg_pkg::desc_t            front_data_s1;
	hcpg_pkg::asc_t             base_pt;

	logic            d_valid [0:CELLS];
	logic            d_ready [0:CELLS];
	hcpg_pkg::desc_t d_data  [0:CELLS];
	logic            a_valid [0:CELLS];
	logic            a_ready [0:CELLS];
	hcpg_pkg::asc_t  a_data  [0:CELLS];

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= hcpg_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// clamp order into the supported range
	always_comb begin
		priority if (order_q == '0) begin
			k_eff = hcpg_pkg::CFG_W'(1);
		end else if (order_q > hcpg_pkg::CFG_W'(hcpg_pkg::ORDER_MAX)) begin
			k_eff = hcpg_pkg::CFG_W'(hcpg_pkg::ORDER_MAX);
		end else begin
			k_eff = order_q;
		end
	end

	// front stage: position counter and index alignment
	assign s_tready  = !front_valid_s1 || d_ready[0];
	assign s_xfer    = s_tvalid && s_tready;
	assign pos_eff   = s_tdata[0] ? '0 : position_q;
	assign total     = hcpg_pkg::POS_W'(1) << {k_eff, 1'b0};
	assign exhausted = pos_eff >= total;
	assign align_sh  = hcpg_pkg::SH_W'(hcpg_pkg::IDX_W - 2 * int'(k_eff));

	always_comb begin
		front_nxt       = '0;
		front_nxt.ok    = !exhausted;
		front_nxt.last  = !exhausted && (pos_eff == total - 1'b1);
		front_nxt.depth = hcpg_pkg::LVL_W'(k_eff - 1'b1);
		front_nxt.cnt   = hcpg_pkg::LVL_W'(k_eff - 1'b1);
		// top index bits line up with the first descending cell
		front_nxt.idx   = pos_eff[hcpg_pkg::IDX_W-1:0] << align_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			front_valid_s1 <= 1'b0;
		end else begin
			if (s_tready) begin
				front_valid_s1 <= s_tvalid;
			end
			// saturates at the end of the curve
			if (s_xfer) begin
				position_q <= exhausted ? pos_eff : pos_eff + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			front_data_s1 <= front_nxt;
		end
	end

	assign d_valid[0] = front_valid_s1;
	assign d_data[0]  = front_data_s1;

	// descending chain, highest level first
	for (genvar gi = 0; gi < CELLS; gi++) begin : g_desc
		hcpg_desc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (d_valid[gi]),
			.in_ready  (d_ready[gi]),
			.in_data   (d_data[gi]),
			.out_valid (d_valid[gi+1]),
			.out_ready (d_ready[gi+1]),
			.out_data  (d_data[gi+1])
		);
	end

	// level-one point from the two remaining index bits
	always_comb begin
		base_pt       = '0;
		base_pt.ok    = d_data[CELLS].ok;
		base_pt.last  = d_data[CELLS].last;
		base_pt.cnt   = d_data[CELLS].depth;
		base_pt.a     = hcpg_pkg::base_x(d_data[CELLS].idx[hcpg_pkg::IDX_W-1 -: 2]);
		base_pt.b     = hcpg_pkg::base_y(d_data[CELLS].idx[hcpg_pkg::IDX_W-1 -: 2]);
		base_pt.n     = hcpg_pkg::COORD_W'(2);
		base_pt.quads = d_data[CELLS].quads;
	end

	assign a_data[0]      = base_pt;
	assign a_valid[0]     = d_valid[CELLS];
	assign d_ready[CELLS] = a_ready[0];

	// ascending chain, level two first
	for (genvar gi = 0; gi < CELLS; gi++) begin : g_asc
		hcpg_asc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (a_valid[gi]),
			.in_ready  (a_ready[gi]),
			.in_data   (a_data[gi]),
			.out_valid (a_valid[gi+1]),
			.out_ready (a_ready[gi+1]),
			.out_data  (a_data[gi+1])
		);
	end

	// last cell doubles as the output register
	assign m_tvalid       = a_valid[CELLS];
	assign a_ready[CELLS] = m_tready;
	assign m_tuser        = a_data[CELLS].ok;
	assign m_tlast        = a_data[CELLS].last;
	assign m_tdata        = a_data[CELLS].ok
		? {{hcpg_pkg::PAD_W{1'b0}}, a_data[CELLS].b, a_data[CELLS].a}
		: '0;

endmodule

// ----- bench/tb_hilbert_curve_point_generator_unit.sv -----
// self-checking testbench for the hilbert curve point generator unit
module tb_hilbert_curve_point_generator_unit;
	import hcpg_pkg::*;

	// one expected or observed result of a point request
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               valid_res;
		logic               last;
	} curve_point_t;

	// tracks order and position, predicts each point, checks results in arrival order
	class hilbert_scoreboard;
		logic [CFG_W-1:0] order_reg;
		int unsigned      position;
		curve_point_t     pending_points[$];
		int               errors;
		int               points_seen;
		int               finals_seen;
		int               exhausted_seen;

		function new();
			order_reg      = CFG_W'(1);
			position       = 0;
			errors         = 0;
			points_seen    = 0;
			finals_seen    = 0;
			exhausted_seen = 0;
		endfunction

		function void write_order(logic [CFG_W-1:0] value);
			order_reg = value;
		endfunction

		// zero acts as one, anything past the maximum is clamped
		function int unsigned active_order();
			if (order_reg == 0)
				return 1;
			if (order_reg > ORDER_MAX)
				return ORDER_MAX;
			return order_reg;
		endfunction

		// index to point: peel quadrants top down, then rebuild the point bottom up
		function curve_point_t walk_point(int unsigned k, int unsigned idx);
			logic [1:0]   quad [ORDER_MAX+1];
			int unsigned  rest, mask, a, b, n, na, nb;
			curve_point_t pt;
			rest = idx;
			for (int lvl = k; lvl >= 2; lvl--) begin
				mask = (1 << (2 * (lvl - 1))) - 1;
				quad[lvl] = 2'((rest >> (2 * (lvl - 1))) & 3);
				rest = rest & mask;
				// the reversed quadrant is walked backward
				if (quad[lvl] == QUAD_REV)
					rest = rest ^ mask;
			end
			// order-1 base: (2,1) (1,1) (1,2) (2,2)
			a = (rest == 0 || rest == 3) ? 2 : 1;
			b = (rest >= 2) ? 2 : 1;
			for (int lvl = 2; lvl <= k; lvl++) begin
				n = 1 << (lvl - 1);
				case (quad[lvl])
					QUAD_REV: begin
						na = b + n;
						nb = n - a + 1;
					end
					QUAD_LL: begin
						na = a;
						nb = b;
					end
					QUAD_UL: begin
						na = a;
						nb = b + n;
					end
					default: begin
						na = b + n;
						nb = a + n;
					end
				endcase
				a = na;
				b = nb;
			end
			pt.x         = COORD_W'(a);
			pt.y         = COORD_W'(b);
			pt.valid_res = 1'b1;
			pt.last      = 1'b0;
			return pt;
		endfunction

		// called on each accepted request transfer
		function void note_request(logic restart);
			int unsigned  k, total;
			curve_point_t pt;
			k     = active_order();
			total = 1 << (2 * k);
			if (restart)
				position = 0;
			if (position >= total) begin
				// exhausted curve: zero result, counter holds
				pt = '0;
			end else begin
				pt      = walk_point(k, position);
				pt.last = (position == total - 1);
				position++;
			end
			pending_points.push_back(pt);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// called on each accepted result transfer
		function void check_point(logic [OUT_W-1:0] data, logic user, logic lst);
			curve_point_t want;
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result, expected none actual x=%0d y=%0d",
					$time, data[COORD_W-1:0], data[2*COORD_W-1:COORD_W]);
				errors++;
				return;
			end
			want = pending_points.pop_front();
			compare_field("x", want.x, data[COORD_W-1:0]);
			compare_field("y", want.y, data[2*COORD_W-1:COORD_W]);
			compare_field("fill", 0, data >> (2 * COORD_W));
			compare_field("valid_res", want.valid_res, user);
			compare_field("last", want.last, lst);
			if (want.valid_res)
				points_seen++;
			else
				exhausted_seen++;
			if (want.last)
				finals_seen++;
		endfunction

		function int pending();
			return pending_points.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	hilbert_scoreboard board;
	int                requests;
	int                restarts;
	int                order_writes;

	hilbert_curve_point_generator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: stretches of ready, short stalls and a few long ones
	initial begin
		int r, len;
		forever begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				m_tready <= 1'b1;
				len = $urandom_range(1, 30);
			end else if (r < 9) begin
				m_tready <= 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				m_tready <= 1'b0;
				len = $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	// every result transfer is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_point(m_tdata, m_tuser, m_tlast);
	end

	// one request transfer, then a random gap unless the phase runs without idling
	task automatic issue(input logic restart, input bit no_idle);
		int r, gap;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(restart);
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(restart);
		requests++;
		if (restart)
			restarts++;
		if (no_idle)
			return;
		r = $urandom_range(0, 19);
		if (r < 12)
			gap = 0;
		else if (r < 18)
			gap = $urandom_range(1, 3);
		else if (r < 19)
			gap = $urandom_range(4, 8);
		else
			gap = $urandom_range(12, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// order is written only with the pipeline drained
	task automatic set_order(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_order(value);
		order_writes++;
	endtask

	initial begin
		int          random_items, r, len, eff;
		logic [CFG_W-1:0] cur_order;
		bit          keep, no_idle, from_start;
		board        = new();
		requests     = 0;
		restarts     = 0;
		order_writes = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset order 1: full walk, then exhausted, then restart
		repeat (4) issue(1'b0, 1'b0);
		issue(1'b0, 1'b0);
		issue(1'b1, 1'b0);
		// all ones clamps to the maximum order
		set_order(CFG_W'(15));
		issue(1'b1, 1'b0);
		repeat (3) issue(1'b0, 1'b0);
		// zero acts as order 1: position 4 is past the end until restart
		set_order(CFG_W'(0));
		issue(1'b0, 1'b0);
		issue(1'b1, 1'b0);
		repeat (3) issue(1'b0, 1'b0);
		// growing the order mid-walk keeps the position
		set_order(CFG_W'(2));
		repeat (7) issue(1'b0, 1'b0);
		// shrinking it leaves the position past the end
		set_order(CFG_W'(1));
		repeat (2) issue(1'b0, 1'b0);
		cur_order = CFG_W'(1);

		// random phases: mostly full walks of small curves, some partial large ones
		random_items = 0;
		while (random_items < 1050) begin
			r    = $urandom_range(0, 19);
			keep = 1'b0;
			if (r < 10)
				cur_order = CFG_W'($urandom_range(1, 4));
			else if (r < 13)
				cur_order = CFG_W'(0);
			else if (r < 16)
				cur_order = CFG_W'($urandom_range(5, 8));
			else if (r < 18)
				cur_order = CFG_W'($urandom_range(9, 15));
			else
				keep = 1'b1;
			if (!keep)
				set_order(cur_order);
			eff = (cur_order == 0) ? 1 : (cur_order > ORDER_MAX) ? ORDER_MAX : cur_order;
			if (eff <= 4)
				len = (1 << (2 * eff)) + $urandom_range(0, 6);
			else
				len = $urandom_range(20, 150);
			// keep the request count close to the target
			if (len > 1050 - random_items)
				len = 1050 - random_items;
			no_idle    = ($urandom_range(0, 3) == 0);
			from_start = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < len; i++) begin
				issue((i == 0 && from_start) || ($urandom_range(0, 49) == 0), no_idle);
				random_items++;
			end
		end

		// drain and give the pipeline time to show any stray result
		s_tvalid <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("ran %0d requests (%0d restarts) across %0d order writes",
			requests, restarts, order_writes);
		$display("checked %0d points, %0d curve ends, %0d exhausted results",
			board.points_seen, board.finals_seen, board.exhausted_seen);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
